/* hw/rtl/m4vsc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MPEG-4 visual start-code scanner package
// Start codes, store sizing and the result record shared by the scanner.
// ----------------------------------------------------------------------------
package m4vsc_pkg;

    // Config store depth and the longest buffer that is counted
    localparam int CONFIG_DEPTH     = 256;
    localparam int MAX_BUFFER_BYTES = 65535;
    localparam int CFG_AW           = $clog2(CONFIG_DEPTH);

    localparam logic [15:0] CFG_DEPTH_POS = 16'(CONFIG_DEPTH);
    localparam logic [15:0] MAX_BUF_POS   = 16'(MAX_BUFFER_BYTES);

    // Start codes
    localparam logic [31:0] CODE_VOS  = 32'h0000_01B0;
    localparam logic [31:0] CODE_GOP  = 32'h0000_01B3;
    localparam logic [31:0] CODE_VOP  = 32'h0000_01B6;
    localparam logic [31:0] CODE_NONE = 32'hFFFF_FFFF;

    // Fixed offsets within a buffer
    localparam logic [15:0] POS_PROFILE   = 16'd4;
    localparam logic [15:0] POS_SCAN_FROM = 16'd5;
    localparam logic [15:0] MIN_BUF_BYTES = 16'd5;
    localparam logic [15:0] TAIL_BYTES    = 16'd4;
    localparam logic [15:0] CODE_BYTES    = 16'd3;

    localparam logic [7:0] PROFILE_RESET = 8'd1;

    typedef struct packed {
        logic        flush_needed;
        logic [15:0] strip_len;
        logic [7:0]  profile_level;
        logic        profile_changed;
        logic        caps_changed;
        logic        config_overflow;
    } res_t;

endpackage : m4vsc_pkg
`default_nettype wire

/* hw/rtl/mpeg4_video_startcode_config_scanner.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MPEG-4 visual start-code and config header scanner
// Byte-wide scan of one elementary-stream buffer; one verdict per buffer.
// ----------------------------------------------------------------------------
// Takes one stream byte per clock while s_ready is high, framed by first/last
// marks, and gives one result transfer for every byte that carries the last
// mark: whether a new RTP packet must start, and for a VOS-led buffer the
// config header length, the profile byte and whether the caps must be
// renewed. The byte with the last mark is registered into stage 2, where the
// registered config store read is compared; the verdict is registered into
// the output register or the skid stage. s_ready drops while two results are
// held between the verdict stage, the output register and the skid stage and
// none leaves in that cycle. A first mark inside an open buffer drops that
// buffer without a result. The config store is a 256 x 8 single-read,
// single-write RAM: offsets 4 to 255 of a VOS buffer are read, compared and
// written back one stage later. No clearing pass is needed; the stored config
// is only trusted once a full header has been written.
// ----------------------------------------------------------------------------
module mpeg4_video_startcode_config_scanner
    import m4vsc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_first_byte,
    input  wire logic        s_last_byte,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_flush_needed,
    output logic [15:0]      m_strip_len,
    output logic [7:0]       m_profile_level,
    output logic             m_profile_changed,
    output logic             m_caps_changed,
    output logic             m_config_overflow
);

    // ------------------------------------------------------------------
    // Per-buffer scan state (stage 1)
    // ------------------------------------------------------------------
    logic [15:0] pos_reg;
    logic [31:0] lead_reg;
    logic [31:0] scan_reg;
    logic        endf_reg;
    logic [15:0] cend_reg;
    logic [7:0]  prof_cap_reg;

    // Persistent config state (updated at the verdict, stage 2; validity also cleared when a VOS buffer is dropped)
    logic [7:0]  profile_reg,    profile_next;
    logic [15:0] stored_len_reg, stored_len_next;
    logic        cfg_valid_reg,  cfg_valid_next;

    // First mismatch against the store within the current buffer
    logic              mm_seen_reg;
    logic [CFG_AW-1:0] mm_pos_reg;

    // Config store
    logic [7:0]        cfg_mem [CONFIG_DEPTH];
    logic [7:0]        rd_data_reg;

    // Stage 2 registers
    logic              s2_acc_reg;
    logic              s2_last_reg;
    logic [CFG_AW-1:0] s2_addr_reg;
    logic [7:0]        s2_byte_reg;
    logic              s2_big_reg;
    logic              s2_vos_reg;
    logic              s2_vop_reg;
    logic [15:0]       s2_cfg_reg;
    logic              s2_ovf_reg;
    logic [7:0]        s2_prof_reg;

    // Output register and skid stage
    logic m_valid_reg;
    res_t out_reg;
    logic skid_valid_reg;
    res_t skid_reg;

    logic s_fire;
    assign s_fire = s_valid && s_ready;

    // ------------------------------------------------------------------
    // Stage 1: position, leading code and end-of-header scan
    // ------------------------------------------------------------------
    logic [15:0] pos_cur, pos_upd;
    logic [31:0] lead_cur, lead_upd;
    logic [31:0] scan_cur, scan_upd;
    logic        endf_cur, endf_upd;
    logic [15:0] cend_cur, cend_upd;
    logic        mem_rd_en;
    logic        prof_cap;
    logic [15:0] lim;
    logic [15:0] cfg_len;
    logic        restart_drop;

    always_comb begin
        // a first mark restarts the buffer before this byte is counted
        pos_cur   = s_first_byte ? '0 : pos_reg;
        lead_cur  = s_first_byte ? '0 : lead_reg;
        scan_cur  = s_first_byte ? CODE_NONE : scan_reg;
        endf_cur  = s_first_byte ? 1'b0 : endf_reg;
        cend_cur  = s_first_byte ? '0 : cend_reg;

        pos_upd   = pos_cur;
        lead_upd  = lead_cur;
        scan_upd  = scan_cur;
        endf_upd  = endf_cur;
        cend_upd  = cend_cur;
        mem_rd_en = 1'b0;
        prof_cap  = 1'b0;

        if (pos_cur < MAX_BUF_POS) begin
            pos_upd = pos_cur + 16'd1;
            if (pos_cur < TAIL_BYTES) begin
                lead_upd = {lead_cur[23:0], s_data_byte};
            end else if (lead_cur == CODE_VOS) begin
                mem_rd_en = (pos_cur < CFG_DEPTH_POS);
                prof_cap  = (pos_cur == POS_PROFILE);
                if (pos_cur >= POS_SCAN_FROM) begin
                    scan_upd = {scan_cur[23:0], s_data_byte};
                    if (!endf_cur && (scan_upd == CODE_GOP || scan_upd == CODE_VOP)) begin
                        endf_upd = 1'b1;
                        cend_upd = pos_cur;
                    end
                end
            end
        end

        // header length: up to the first GOP/VOP code, else size-7 floored at 2
        lim = pos_upd - TAIL_BYTES;
        if (endf_upd && cend_upd < lim) begin
            cfg_len = cend_upd - CODE_BYTES;
        end else if (lim > MIN_BUF_BYTES) begin
            cfg_len = lim - CODE_BYTES;
        end else begin
            cfg_len = MIN_BUF_BYTES - CODE_BYTES;
        end

        // dropping a VOS buffer that already touched the store
        restart_drop = s_first_byte && lead_reg == CODE_VOS && pos_reg > POS_PROFILE;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            lead_reg <= '0;
            scan_reg <= CODE_NONE;
            endf_reg <= 1'b0;
            cend_reg <= '0;
        end else if (s_fire) begin
            if (s_last_byte) begin
                pos_reg  <= '0;
                lead_reg <= '0;
                scan_reg <= CODE_NONE;
                endf_reg <= 1'b0;
                cend_reg <= '0;
            end else begin
                pos_reg  <= pos_upd;
                lead_reg <= lead_upd;
                scan_reg <= scan_upd;
                endf_reg <= endf_upd;
                cend_reg <= cend_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && prof_cap) begin
            prof_cap_reg <= s_data_byte;
        end
    end

    // stage 1 -> stage 2 hand-over
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_acc_reg  <= 1'b0;
            s2_last_reg <= 1'b0;
        end else begin
            s2_acc_reg  <= s_fire && mem_rd_en;
            s2_last_reg <= s_fire && s_last_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s2_addr_reg <= pos_cur[CFG_AW-1:0];
            s2_byte_reg <= s_data_byte;
            s2_big_reg  <= (pos_upd >= MIN_BUF_BYTES);
            s2_vos_reg  <= (lead_upd == CODE_VOS);
            s2_vop_reg  <= (lead_upd == CODE_VOP);
            s2_cfg_reg  <= cfg_len;
            s2_ovf_reg  <= (cfg_len > CFG_DEPTH_POS);
            s2_prof_reg <= prof_cap ? s_data_byte : prof_cap_reg;
        end
    end

    // ------------------------------------------------------------------
    // Config store: registered read in stage 1, write-back in stage 2.
    // Within a buffer each entry is touched once, and offsets 0..3 lie
    // between buffers, so a read never meets a pending write to its entry.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (s_fire && mem_rd_en) begin
            rd_data_reg <= cfg_mem[pos_cur[CFG_AW-1:0]];
        end
        if (s2_acc_reg) begin
            cfg_mem[s2_addr_reg] <= s2_byte_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: compare, first-mismatch tracking and verdict
    // ------------------------------------------------------------------
    logic              mm_hit;
    logic              mm_seen_now;
    logic [CFG_AW-1:0] mm_pos_now;
    logic              cfg_equal;
    logic              new_prof;
    logic              caps_chg;
    res_t              s2_res;

    always_comb begin
        mm_hit      = s2_acc_reg && (rd_data_reg != s2_byte_reg);
        mm_seen_now = mm_seen_reg || mm_hit;
        mm_pos_now  = mm_seen_reg ? mm_pos_reg : s2_addr_reg;

        new_prof  = (s2_prof_reg != profile_reg);
        cfg_equal = cfg_valid_reg && !s2_ovf_reg && stored_len_reg == s2_cfg_reg &&
                    (!mm_seen_now || {{(16-CFG_AW){1'b0}}, mm_pos_now} >= s2_cfg_reg);
        caps_chg  = !cfg_equal || new_prof;

        profile_next    = profile_reg;
        stored_len_next = stored_len_reg;
        cfg_valid_next  = cfg_valid_reg;

        s2_res                 = '0;
        s2_res.profile_level   = profile_reg;

        if (s2_last_reg && s2_big_reg) begin
            if (s2_vos_reg) begin
                profile_next           = s2_prof_reg;
                s2_res.flush_needed    = 1'b1;
                s2_res.strip_len       = s2_cfg_reg;
                s2_res.profile_level   = s2_prof_reg;
                s2_res.profile_changed = new_prof;
                s2_res.caps_changed    = caps_chg;
                s2_res.config_overflow = s2_ovf_reg;
                if (caps_chg) begin
                    stored_len_next = s2_ovf_reg ? '0 : s2_cfg_reg;
                    cfg_valid_next  = !s2_ovf_reg;
                end
            end else begin
                s2_res.flush_needed = !s2_vop_reg;
            end
        end

        // a dropped VOS buffer leaves the store half-written
        if (s_fire && restart_drop) begin
            cfg_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            profile_reg    <= PROFILE_RESET;
            stored_len_reg <= '0;
            cfg_valid_reg  <= 1'b0;
        end else begin
            profile_reg    <= profile_next;
            stored_len_reg <= stored_len_next;
            cfg_valid_reg  <= cfg_valid_next;
        end
    end

    // mismatch tracking restarts with each new buffer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mm_seen_reg <= 1'b0;
        end else if (s_fire && pos_cur == '0) begin
            mm_seen_reg <= 1'b0;
        end else if (mm_hit && !mm_seen_reg) begin
            mm_seen_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (mm_hit && !mm_seen_reg) begin
            mm_pos_reg <= s2_addr_reg;
        end
    end

    // ------------------------------------------------------------------
    // Output register with one skid entry
    // ------------------------------------------------------------------
    logic       out_free;
    logic [1:0] pend_cnt;

    assign out_free = !m_valid_reg || m_ready;
    assign pend_cnt = {1'b0, s2_last_reg} + {1'b0, m_valid_reg} + {1'b0, skid_valid_reg}
                    - {1'b0, m_valid_reg && m_ready};
    assign s_ready  = (pend_cnt < 2'd2);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_valid_reg) begin
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= s2_last_reg;
            end else begin
                m_valid_reg    <= s2_last_reg;
            end
        end else if (s2_last_reg) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (skid_valid_reg) begin
                out_reg  <= skid_reg;
                skid_reg <= s2_res;
            end else begin
                out_reg  <= s2_res;
            end
        end else if (s2_last_reg) begin
            skid_reg <= s2_res;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_flush_needed    = out_reg.flush_needed;
    assign m_strip_len       = out_reg.strip_len;
    assign m_profile_level   = out_reg.profile_level;
    assign m_profile_changed = out_reg.profile_changed;
    assign m_caps_changed    = out_reg.caps_changed;
    assign m_config_overflow = out_reg.config_overflow;

`ifndef SYNTHESIS
    // store read never targets the entry being written back
    a_no_rw_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && mem_rd_en && s2_acc_reg) |-> (pos_cur[CFG_AW-1:0] != s2_addr_reg))
        else $error("config store read and write hit the same entry");

    // at most two results in flight
    a_pend_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones({s2_last_reg, m_valid_reg, skid_valid_reg}) <= 2)
        else $error("result storage overrun");

    // skid only holds a result behind a waiting output
    a_skid_order: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid holds a result with the output register empty");

    // a held header always fits the store
    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid_reg |-> (stored_len_reg <= CFG_DEPTH_POS))
        else $error("stored config length beyond store depth");
`endif

endmodule : mpeg4_video_startcode_config_scanner
`default_nettype wire
